### rtl/rvq_pkg.sv
// Shared constants and elaboration-time helpers for the rotation vector to
// quaternion converter. Depends on nothing; the top level imports it.
package rvq_pkg;

  localparam int IN_FRAC_BITS  = 28;
  localparam int OUT_FRAC_BITS = 30;
  localparam int CORDIC_STEPS  = 32;

  localparam int SQRT_STEPS  = 32;
  localparam int RATIO_STEPS = 32;
  localparam int NORM_STEPS  = 33;
  localparam int PHASE_BITS  = 48;
  localparam int PHASE_SHIFT = IN_FRAC_BITS + 1 + 64 - PHASE_BITS;
  localparam int REM_BITS    = PHASE_BITS - 2;

  localparam logic [63:0] PI_Q60         = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] TWO_PI_Q60     = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

  localparam int OUT_UP = (OUT_FRAC_BITS >= 32) ? OUT_FRAC_BITS - 32 : 0;
  localparam int OUT_DN = (OUT_FRAC_BITS < 32) ? 32 - OUT_FRAC_BITS : 1;
  localparam logic [63:0] OUT_RND = 64'd1 << (OUT_DN - 1);
  localparam logic [63:0] OUT_ONE = 64'd1 << OUT_FRAC_BITS;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    begin
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[63:0], num[b]};
        if (rem >= {1'b0, den}) begin
          rem = rem - {1'b0, den};
          quo[b] = 1'b1;
        end
      end
      return quo;
    end
  endfunction

  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    begin
      acc = '0;
      if (i == 0) begin
        acc = PI_Q60 >> 2;
      end else begin
        for (int k = 0; k < 31; k++) begin
          e = i * (2 * k + 1);
          if (e <= 60) begin
            term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
            if ((k & 1) == 1) acc = acc - term;
            else acc = acc + term;
          end
        end
      end
      return acc;
    end
  endfunction

endpackage

### rtl/rvq_sqrt_cell.sv
// One digit step of the floor square root.
// Standalone; chained by the top level, one cell per result bit.
module rvq_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  step,
  input  logic [63:0] n_in,
  input  logic [63:0] r_in,
  output logic [63:0] n_out,
  output logic [63:0] r_out
);

  logic [63:0] bit_val;
  logic [63:0] trial;
  logic        ge;

  always_comb begin
    bit_val = 64'd1 << (6'd62 - {step, 1'b0});
    trial   = r_in + bit_val;
    ge      = (n_in >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out <= ge ? n_in - trial : n_in;
      r_out <= ge ? (r_in >> 1) + bit_val : r_in >> 1;
    end
  end

endmodule

### rtl/rvq_div_cell.sv
// One quotient bit of a restoring divider.
// Standalone; chained by the top level, most significant bit first.
module rvq_div_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [5:0]  shift,
  input  logic [63:0] den,
  input  logic [63:0] rem_in,
  input  logic [32:0] quo_in,
  output logic [63:0] rem_out,
  output logic [32:0] quo_out
);

  logic ge;

  assign ge = ((rem_in >> shift) >= den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rem_in - (den << shift) : rem_in;
      quo_out <= {quo_in[31:0], ge};
    end
  end

endmodule

### rtl/rvq_cordic_cell.sv
// One rotation step of the CORDIC sine and cosine unit.
// Standalone; the step shift and arctangent come from the top level.
module rvq_cordic_cell (
  input  logic               clk,
  input  logic               en,
  input  logic [5:0]         shift,
  input  logic [63:0]        angle,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  input  logic [63:0]        z_in,
  output logic signed [63:0] x_out,
  output logic signed [63:0] y_out,
  output logic [63:0]        z_out
);

  logic signed [63:0] dx;
  logic signed [63:0] dy;

  assign dx = y_in >>> shift;
  assign dy = x_in >>> shift;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in[63]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + angle;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - angle;
      end
    end
  end

endmodule

### rtl/rotation_vector_to_quaternion.sv
// Rotation vector to unit quaternion converter, fully pipelined.
// Depends on rvq_pkg, rvq_sqrt_cell, rvq_div_cell and rvq_cordic_cell.
//
// One rotation vector is taken every clock cycle while rot_stall is low; its
// quaternion passes a chain of one-bit cells: two 32-step square roots, a
// 32-step and a 33-step divider and a 32-step CORDIC, plus twelve arithmetic
// stages and the output register. A two-entry output buffer keeps the pipe
// moving while a result waits; rot_stall rises only when both entries are
// full.
module rotation_vector_to_quaternion import rvq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rot_valid,
  output logic               rot_stall,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  output logic               quat_valid,
  input  logic               quat_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z
);

  typedef struct packed {
    logic [31:0]      len;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } front_t;

  typedef struct packed {
    logic [1:0]       quad;
    logic [2:0][31:0] ratio;
    logic             lz;
    logic [2:0]       vneg;
  } mid_t;

  typedef struct packed {
    logic [3:0][31:0] part;
    logic [3:0]       pneg;
    logic             qz;
  } back_t;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } quat_t;

  logic       en;
  logic [1:0] cnt;

  assign en        = (cnt != 2'd2);
  assign rot_stall = !en;

  // Input magnitudes, squares and their sum.
  logic   a_vld, b_vld, c_vld;
  front_t a_fr, b_fr, c_fr;
  logic [2:0][63:0] b_sq;
  logic [63:0]      c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= rot_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_fr.len    <= '0;
      a_fr.mag[0] <= rot_x[31] ? 32'(-rot_x) : 32'(rot_x);
      a_fr.mag[1] <= rot_y[31] ? 32'(-rot_y) : 32'(rot_y);
      a_fr.mag[2] <= rot_z[31] ? 32'(-rot_z) : 32'(rot_z);
      a_fr.neg    <= {rot_z[31], rot_y[31], rot_x[31]};
      b_fr        <= a_fr;
      for (int j = 0; j < 3; j++) begin
        b_sq[j] <= 64'(a_fr.mag[j]) * 64'(a_fr.mag[j]);
      end
      c_fr  <= b_fr;
      c_sum <= b_sq[0] + b_sq[1] + b_sq[2];
    end
  end

  // Vector length.
  logic        s1_vld [0:SQRT_STEPS];
  front_t      s1_fr  [0:SQRT_STEPS];
  logic [63:0] s1_n   [0:SQRT_STEPS];
  logic [63:0] s1_r   [0:SQRT_STEPS];

  assign s1_vld[0] = c_vld;
  assign s1_fr[0]  = c_fr;
  assign s1_n[0]   = c_sum;
  assign s1_r[0]   = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_s1
    rvq_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .step  (5'(k)),
      .n_in  (s1_n[k]),
      .r_in  (s1_r[k]),
      .n_out (s1_n[k+1]),
      .r_out (s1_r[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) s1_vld[k+1] <= 1'b0;
      else if (en) s1_vld[k+1] <= s1_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) s1_fr[k+1] <= s1_fr[k];
    end
  end

  // Ratios of each component to the length.
  logic        d1_vld [0:RATIO_STEPS];
  front_t      d1_fr  [0:RATIO_STEPS];
  logic [63:0] d1_rem [0:RATIO_STEPS][0:2];
  logic [32:0] d1_quo [0:RATIO_STEPS][0:2];

  always_comb begin
    d1_vld[0]     = s1_vld[SQRT_STEPS];
    d1_fr[0]      = s1_fr[SQRT_STEPS];
    d1_fr[0].len  = s1_r[SQRT_STEPS][31:0];
    for (int j = 0; j < 3; j++) begin
      d1_rem[0][j] = 64'(s1_fr[SQRT_STEPS].mag[j]) << 31;
      d1_quo[0][j] = '0;
    end
  end

  for (genvar k = 0; k < RATIO_STEPS; k++) begin : g_d1
    for (genvar j = 0; j < 3; j++) begin : g_lane
      rvq_div_cell u_cell (
        .clk     (clk),
        .en      (en),
        .shift   (6'(RATIO_STEPS - 1 - k)),
        .den     (64'(d1_fr[k].len)),
        .rem_in  (d1_rem[k][j]),
        .quo_in  (d1_quo[k][j]),
        .rem_out (d1_rem[k+1][j]),
        .quo_out (d1_quo[k+1][j])
      );
    end
    always_ff @(posedge clk) begin
      if (rst) d1_vld[k+1] <= 1'b0;
      else if (en) d1_vld[k+1] <= d1_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) d1_fr[k+1] <= d1_fr[k];
    end
  end

  // Phase reduction of the half angle.
  logic              p1_vld, p2_vld, p3_vld, p4_vld;
  mid_t              p1_md, p2_md, p3_md, p4_md;
  logic [63:0]       p1_lo, p1_hi;
  logic [127:0]      p2_prod;
  logic [REM_BITS-1:0] p2_rem;
  logic [54:0]       p3_ll, p3_lh, p3_hl, p3_hh;
  logic [127:0]      p4_prod;
  logic [63:0]       p4_z;
  mid_t              p1_md_next, p2_md_next;

  always_comb begin
    p1_md_next.quad = '0;
    p1_md_next.lz   = (d1_fr[RATIO_STEPS].len == '0);
    p1_md_next.vneg = d1_fr[RATIO_STEPS].neg;
    for (int j = 0; j < 3; j++) begin
      p1_md_next.ratio[j] = d1_quo[RATIO_STEPS][j][31:0];
    end
    p2_prod = 128'(p1_lo) + (128'(p1_hi) << 32);
    p2_md_next      = p1_md;
    p2_md_next.quad = p2_prod[PHASE_SHIFT+PHASE_BITS-1 -: 2];
    p4_prod = 128'(p3_ll) + (128'(p3_lh) << 32) + (128'(p3_hl) << 23)
              + (128'(p3_hh) << 55);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= d1_vld[RATIO_STEPS];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_md   <= p1_md_next;
      p1_lo   <= 64'(d1_fr[RATIO_STEPS].len) * 64'(INV_TWO_PI_Q64[31:0]);
      p1_hi   <= 64'(d1_fr[RATIO_STEPS].len) * 64'(INV_TWO_PI_Q64[63:32]);
      p2_md      <= p2_md_next;
      p2_rem     <= p2_prod[PHASE_SHIFT +: REM_BITS];
      p3_md   <= p2_md;
      p3_ll   <= 55'(p2_rem[22:0]) * 55'(TWO_PI_Q60[31:0]);
      p3_lh   <= 55'(p2_rem[22:0]) * 55'(TWO_PI_Q60[63:32]);
      p3_hl   <= 55'(p2_rem[REM_BITS-1:23]) * 55'(TWO_PI_Q60[31:0]);
      p3_hh   <= 55'(p2_rem[REM_BITS-1:23]) * 55'(TWO_PI_Q60[63:32]);
      p4_md   <= p3_md;
      p4_z    <= p4_prod[111:48];
    end
  end

  // Sine and cosine.
  logic               cr_vld [0:CORDIC_STEPS];
  mid_t               cr_md  [0:CORDIC_STEPS];
  logic signed [63:0] cr_x   [0:CORDIC_STEPS];
  logic signed [63:0] cr_y   [0:CORDIC_STEPS];
  logic [63:0]        cr_z   [0:CORDIC_STEPS];

  assign cr_vld[0] = p4_vld;
  assign cr_md[0]  = p4_md;
  assign cr_x[0]   = 64'sd1 <<< 60;
  assign cr_y[0]   = '0;
  assign cr_z[0]   = p4_z;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cr
    localparam logic [63:0] ATAN_K = atan_q60(k);
    rvq_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .shift (6'(k)),
      .angle (ATAN_K),
      .x_in  (cr_x[k]),
      .y_in  (cr_y[k]),
      .z_in  (cr_z[k]),
      .x_out (cr_x[k+1]),
      .y_out (cr_y[k+1]),
      .z_out (cr_z[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) cr_vld[k+1] <= 1'b0;
      else if (en) cr_vld[k+1] <= cr_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) cr_md[k+1] <= cr_md[k];
    end
  end

  // Quadrant, rounding, vector parts and their squared norm.
  logic               q1_vld, q2_vld, q3_vld, q4_vld, q5_vld;
  mid_t               q1_md, q2_md;
  logic [31:0]        q1_cmag, q1_smag, q2_cmag;
  logic               q1_cneg, q1_sneg, q2_cneg, q2_sneg;
  logic [2:0][63:0]   q2_prod;
  back_t              q3_bk, q4_bk, q5_bk, q3_bk_next;
  logic [3:0][63:0]   q4_sq;
  logic [63:0]        q5_sum;
  logic signed [63:0] q_c, q_s;
  logic [63:0]        q_cm, q_sm, q_ct, q_st;
  mid_t               q_in;

  always_comb begin
    q_in = cr_md[CORDIC_STEPS];
    case (q_in.quad)
      2'd0: begin
        q_c = cr_x[CORDIC_STEPS];
        q_s = cr_y[CORDIC_STEPS];
      end
      2'd1: begin
        q_c = 64'sd0 - cr_y[CORDIC_STEPS];
        q_s = cr_x[CORDIC_STEPS];
      end
      2'd2: begin
        q_c = 64'sd0 - cr_x[CORDIC_STEPS];
        q_s = 64'sd0 - cr_y[CORDIC_STEPS];
      end
      default: begin
        q_c = cr_y[CORDIC_STEPS];
        q_s = 64'sd0 - cr_x[CORDIC_STEPS];
      end
    endcase
    q_cm = q_c[63] ? 64'd0 - 64'(q_c) : 64'(q_c);
    q_sm = q_s[63] ? 64'd0 - 64'(q_s) : 64'(q_s);
    q_ct = q_cm + (64'd1 << 29);
    q_st = q_sm + (64'd1 << 29);

    q3_bk_next.qz      = 1'b0;
    q3_bk_next.part[0] = q2_cmag;
    q3_bk_next.pneg[0] = q2_cneg && (q2_cmag != '0);
    for (int j = 0; j < 3; j++) begin
      q3_bk_next.part[j+1] = q2_md.lz ? '0 : q2_prod[j][62:31];
      q3_bk_next.pneg[j+1] = !q2_md.lz && (q2_sneg != q2_md.vneg[j])
                             && (q2_prod[j][62:31] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
      q2_vld <= 1'b0;
      q3_vld <= 1'b0;
      q4_vld <= 1'b0;
      q5_vld <= 1'b0;
    end else if (en) begin
      q1_vld <= cr_vld[CORDIC_STEPS];
      q2_vld <= q1_vld;
      q3_vld <= q2_vld;
      q4_vld <= q3_vld;
      q5_vld <= q4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_md   <= q_in;
      q1_cmag <= q_ct[61:30];
      q1_smag <= q_st[61:30];
      q1_cneg <= q_c[63];
      q1_sneg <= q_s[63];
      q2_md   <= q1_md;
      q2_cmag <= q1_cmag;
      q2_cneg <= q1_cneg;
      q2_sneg <= q1_sneg;
      for (int j = 0; j < 3; j++) begin
        q2_prod[j] <= 64'(q1_smag) * 64'(q1_md.ratio[j]);
      end
      q3_bk <= q3_bk_next;
      q4_bk <= q3_bk;
      for (int j = 0; j < 4; j++) begin
        q4_sq[j] <= 64'(q3_bk.part[j]) * 64'(q3_bk.part[j]);
      end
      q5_bk  <= q4_bk;
      q5_sum <= q4_sq[0] + q4_sq[1] + q4_sq[2] + q4_sq[3];
    end
  end

  // Norm of the four parts.
  logic        s2_vld [0:SQRT_STEPS];
  back_t       s2_bk  [0:SQRT_STEPS];
  logic [63:0] s2_n   [0:SQRT_STEPS];
  logic [63:0] s2_r   [0:SQRT_STEPS];

  assign s2_vld[0] = q5_vld;
  assign s2_bk[0]  = q5_bk;
  assign s2_n[0]   = q5_sum;
  assign s2_r[0]   = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_s2
    rvq_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .step  (5'(k)),
      .n_in  (s2_n[k]),
      .r_in  (s2_r[k]),
      .n_out (s2_n[k+1]),
      .r_out (s2_r[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) s2_vld[k+1] <= 1'b0;
      else if (en) s2_vld[k+1] <= s2_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) s2_bk[k+1] <= s2_bk[k];
    end
  end

  // Normalization.
  logic        d2_vld [0:NORM_STEPS];
  back_t       d2_bk  [0:NORM_STEPS];
  logic [63:0] d2_den [0:NORM_STEPS];
  logic [63:0] d2_rem [0:NORM_STEPS][0:3];
  logic [32:0] d2_quo [0:NORM_STEPS][0:3];

  always_comb begin
    d2_vld[0]   = s2_vld[SQRT_STEPS];
    d2_bk[0]    = s2_bk[SQRT_STEPS];
    d2_bk[0].qz = (s2_r[SQRT_STEPS][32:0] == '0);
    d2_den[0]   = 64'(s2_r[SQRT_STEPS][32:0]);
    for (int j = 0; j < 4; j++) begin
      d2_rem[0][j] = 64'(s2_bk[SQRT_STEPS].part[j]) << 32;
      d2_quo[0][j] = '0;
    end
  end

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_d2
    for (genvar j = 0; j < 4; j++) begin : g_lane
      rvq_div_cell u_cell (
        .clk     (clk),
        .en      (en),
        .shift   (6'(NORM_STEPS - 1 - k)),
        .den     (d2_den[k]),
        .rem_in  (d2_rem[k][j]),
        .quo_in  (d2_quo[k][j]),
        .rem_out (d2_rem[k+1][j]),
        .quo_out (d2_quo[k+1][j])
      );
    end
    always_ff @(posedge clk) begin
      if (rst) d2_vld[k+1] <= 1'b0;
      else if (en) d2_vld[k+1] <= d2_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d2_bk[k+1]  <= d2_bk[k];
        d2_den[k+1] <= d2_den[k];
      end
    end
  end

  function automatic logic [31:0] emit(input logic [31:0] mag, input logic neg,
                                       input logic qz, input logic [32:0] quo);
    logic [63:0] q32;
    logic [63:0] v;
    logic [31:0] res;
    begin
      q32 = qz ? {30'd0, mag, 2'b00} : {31'd0, quo};
      if (OUT_FRAC_BITS >= 32) v = q32 << OUT_UP;
      else v = (q32 + OUT_RND) >> OUT_DN;
      if (v > OUT_ONE) v = OUT_ONE;
      if (neg) begin
        if (v > 64'h8000_0000) v = 64'h8000_0000;
        res = v[31:0];
        res = 32'd0 - res;
      end else begin
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        res = v[31:0];
      end
      return res;
    end
  endfunction

  // Output buffer, two entries.
  back_t e_bk;
  quat_t e_q;
  quat_t buf0, buf1;
  logic  push, pop;
  logic [1:0] cnt_next;

  always_comb begin
    e_bk   = d2_bk[NORM_STEPS];
    e_q.w  = emit(e_bk.part[0], e_bk.pneg[0], e_bk.qz, d2_quo[NORM_STEPS][0]);
    e_q.x  = emit(e_bk.part[1], e_bk.pneg[1], e_bk.qz, d2_quo[NORM_STEPS][1]);
    e_q.y  = emit(e_bk.part[2], e_bk.pneg[2], e_bk.qz, d2_quo[NORM_STEPS][2]);
    e_q.z  = emit(e_bk.part[3], e_bk.pneg[3], e_bk.qz, d2_quo[NORM_STEPS][3]);
    push     = d2_vld[NORM_STEPS] && en;
    pop      = quat_valid && !quat_stall;
    cnt_next = cnt + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else cnt <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) buf0 <= buf1;
    if (push) begin
      if ((cnt - 2'(pop)) == 2'd0) buf0 <= e_q;
      else buf1 <= e_q;
    end
  end

  assign quat_valid = (cnt != 2'd0);
  assign quat_w     = buf0.w;
  assign quat_x     = buf0.x;
  assign quat_y     = buf0.y;
  assign quat_z     = buf0.z;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    rot_stall |-> (quat_valid && cnt == 2'd2))
    else $error("input stalled while output buffer has room");
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (quat_valid && quat_stall) |=> (cnt >= $past(cnt)))
    else $error("result lost while output stalled");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    d2_vld[NORM_STEPS] && en |-> cnt != 2'd2)
    else $error("push into full output buffer");
`endif

endmodule
